[hw/rtl/clcd_pkg.sv]
// Shared types, constants and tables for the character-LCD byte sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  // Command codes on the input stream
  typedef enum logic [2:0] {
    FUNC_INIT  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_SETCUR = 3'd2,
    FUNC_HOME  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] REG_NUM_COLS = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS = 2'd1;
  localparam logic [1:0] REG_DEV_ADDR = 2'd2;

  // Configuration reset values
  localparam logic [5:0] NUM_COLS_RST = 6'd20;
  localparam logic [2:0] NUM_ROWS_RST = 3'd4;
  localparam logic [6:0] DEV_ADDR_RST = 7'd39;

  // Default depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Display command bytes
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  // Wait figures in microseconds
  localparam logic [13:0] WAIT_NONE   = 14'd0;
  localparam logic [13:0] WAIT_ENABLE = 14'd1;
  localparam logic [13:0] WAIT_SHORT  = 14'd500;
  localparam logic [13:0] WAIT_SETUP  = 14'd580;
  localparam logic [13:0] WAIT_LONG   = 14'd2500;
  localparam logic [13:0] WAIT_RST1   = 14'd10500;
  localparam logic [13:0] WAIT_RST2   = 14'd700;

  // Index of the last nibble of the init sequence (nibbles 0 to 11)
  localparam logic [3:0] INIT_LAST_NIB = 4'd11;

  // Kinds of work handed from front to back
  typedef enum logic [1:0] {
    JOB_INIT  = 2'd0,
    JOB_BYTE  = 2'd1,
    JOB_NOBUS = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;       // byte to send for JOB_BYTE
    logic        rs;         // register select for JOB_BYTE
    logic        long_wait;  // final wait is the long one (home, clear)
    logic        status;     // not-initialised flag for JOB_NOBUS
  } job_t;

  // DDRAM base address of each row
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Nibble sent at each step of the init sequence
  function automatic logic [3:0] init_nib(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5:             n = 4'h8;
      4'd6:             n = 4'h0;
      4'd7:             n = 4'h1;
      4'd8:             n = 4'h0;
      4'd9:             n = 4'h6;
      4'd10:            n = 4'h0;
      4'd11:            n = 4'hC;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  // Wait after the enable-low write of each init nibble
  function automatic logic [13:0] init_wait(input logic [3:0] idx);
    logic [13:0] w;
    case (idx)
      4'd0:    w = WAIT_RST1;
      4'd1:    w = WAIT_RST2;
      4'd2:    w = WAIT_SHORT;
      4'd3:    w = WAIT_SETUP;
      4'd5:    w = WAIT_SETUP;
      4'd7:    w = WAIT_LONG;
      4'd9:    w = WAIT_SETUP;
      default: w = WAIT_SHORT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/clcd_queue.sv]
// Small request queue between the command front and the transaction back.
// Depends on clcd_pkg for the job_t request type.
`timescale 1ns / 1ps
`default_nettype none

module clcd_queue
  import clcd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/clcd_front.sv]
// Command front: holds configuration and the initialised flag, classifies
// each command and works out the byte to send. Depends on clcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clcd_front
  import clcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // command request
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire logic [2:0] func,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] col,
  input  wire logic [7:0] row,
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  // towards the queue
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job,
  output logic [6:0]      device_address
);

  logic [5:0] num_cols;
  logic [2:0] num_rows;
  logic       initialized;

  logic [1:0] last_row;
  logic [1:0] row_c;
  logic [7:0] col_c;
  logic [7:0] cur_addr;

  assign cmd_ready = !q_full;
  assign q_push    = cmd_valid && cmd_ready;
  assign cfg_ready = 1'b1;

  // cursor address: clamp row, wrap oversize column to 0, add row base
  always_comb begin
    if (num_rows == 3'd0) begin
      last_row = 2'd0;
    end else if (num_rows > 3'd4) begin
      last_row = 2'd3;
    end else begin
      last_row = 2'(num_rows - 3'd1);
    end
    row_c    = (row > {6'd0, last_row}) ? last_row : row[1:0];
    col_c    = (col >= {2'd0, num_cols}) ? 8'd0 : col;
    cur_addr = CMD_SET_DDRAM | 8'(col_c + row_base(row_c));
  end

  // classify the command
  always_comb begin
    q_job.kind      = JOB_BYTE;
    q_job.data      = 8'd0;
    q_job.rs        = 1'b0;
    q_job.long_wait = 1'b0;
    q_job.status    = 1'b0;
    if (func == FUNC_INIT) begin
      q_job.kind = JOB_INIT;
    end else if (!initialized) begin
      q_job.kind   = JOB_NOBUS;
      q_job.status = 1'b1;
    end else begin
      case (func)
        FUNC_WRITE: begin
          q_job.data = char_code;
          q_job.rs   = 1'b1;
        end
        FUNC_SETCUR: begin
          q_job.data = cur_addr;
        end
        FUNC_HOME: begin
          q_job.data      = CMD_HOME;
          q_job.long_wait = 1'b1;
        end
        FUNC_CLEAR: begin
          q_job.data      = CMD_CLEAR;
          q_job.long_wait = 1'b1;
        end
        default: begin
          q_job.kind = JOB_NOBUS;
        end
      endcase
    end
  end

  // configuration registers and initialised flag
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols       <= NUM_COLS_RST;
      num_rows       <= NUM_ROWS_RST;
      device_address <= DEV_ADDR_RST;
      initialized    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_COLS: num_cols       <= cfg_data[5:0];
          REG_NUM_ROWS: num_rows       <= cfg_data[2:0];
          REG_DEV_ADDR: device_address <= cfg_data;
          default: ;
        endcase
      end
      if (q_push && func == FUNC_INIT) begin
        initialized <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/clcd_back.sv]
// Transaction back: steps through nibbles and enable phases of the request
// at the queue head, one expander write per cycle unless stalled. Depends on clcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clcd_back
  import clcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire job_t       head,
  input  wire logic       q_empty,
  output logic            q_pop,
  input  wire logic [6:0] device_address,
  // result stream
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [7:0]      address_byte,
  output logic [7:0]      expander_byte,
  output logic            bus_write,
  output logic [13:0]     wait_us,
  output logic            status,
  output logic            last
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_EN_HI,
    PH_EN_LO
  } phase_t;

  phase_t     phase;
  logic [3:0] nib_idx;

  logic        advance;
  logic [3:0]  nib;
  logic [13:0] final_wait;
  logic        last_nib;
  logic        rs;
  logic [7:0]  d;
  logic [7:0]  exp_b;
  logic [13:0] wt;
  logic        nobus;
  logic        item_last;

  // a result moves into the output register when it is free or draining
  assign advance = !q_empty && (!res_valid || res_ready);
  assign q_pop   = advance && item_last;
  assign nobus   = (head.kind == JOB_NOBUS);

  // nibble, final wait and register select of the current step
  always_comb begin
    nib        = 4'd0;
    final_wait = WAIT_SHORT;
    last_nib   = 1'b1;
    rs         = 1'b0;
    case (head.kind)
      JOB_INIT: begin
        nib        = init_nib(nib_idx);
        final_wait = init_wait(nib_idx);
        last_nib   = (nib_idx == INIT_LAST_NIB);
      end
      JOB_BYTE: begin
        nib        = nib_idx[0] ? head.data[3:0] : head.data[7:4];
        final_wait = (nib_idx[0] && head.long_wait) ? WAIT_LONG : WAIT_SHORT;
        last_nib   = nib_idx[0];
        rs         = head.rs;
      end
      default: ;
    endcase
  end

  // expander byte: nibble on D7-D4, backlight on, enable per phase
  always_comb begin
    d = {nib, 1'b1, 1'b0, 1'b0, rs};
    case (phase)
      PH_DATA: begin
        exp_b = d;
        wt    = WAIT_NONE;
      end
      PH_EN_HI: begin
        exp_b = d | 8'h04;
        wt    = WAIT_ENABLE;
      end
      PH_EN_LO: begin
        exp_b = d;
        wt    = final_wait;
      end
      default: begin
        exp_b = d;
        wt    = WAIT_NONE;
      end
    endcase
    item_last = nobus || (phase == PH_EN_LO && last_nib);
  end

  // step counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      nib_idx   <= 4'd0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
        if (item_last) begin
          phase   <= PH_DATA;
          nib_idx <= 4'd0;
        end else begin
          case (phase)
            PH_DATA:  phase <= PH_EN_HI;
            PH_EN_HI: phase <= PH_EN_LO;
            default: begin
              phase   <= PH_DATA;
              nib_idx <= nib_idx + 4'd1;
            end
          endcase
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      address_byte  <= nobus ? 8'd0 : {device_address, 1'b0};
      expander_byte <= nobus ? 8'd0 : exp_b;
      bus_write     <= !nobus;
      wait_us       <= nobus ? WAIT_NONE : wt;
      status        <= nobus && head.status;
      last          <= item_last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/char_lcd_i2c_byte_sequencer.sv]
// Character-LCD command sequencer: front, request queue and back, with
// stream ports for commands and expander writes. Depends on clcd_pkg.
// Throughput: one result per cycle from the back while m_tready allows;
// a character, cursor, home or clear command gives 6 results, init 36,
// a rejected command 1. Commands keep being accepted while the queue
// (QUEUE_DEPTH deep) has room.
// Reset (rst, synchronous): clears the initialised flag, the queue and the
// output; configuration returns to 20 columns, 4 rows, address 39.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_i2c_byte_sequencer
  import clcd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], col[15:8], row[23:16]
  input  wire logic [2:0]  s_tuser,   // func[2:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // address_byte[7:0], expander_byte[15:8], wait_us[29:16]
  output logic [1:0]       m_tuser,   // bus_write[0], status[1]
  output logic             m_tlast,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  job_t        push_job;
  job_t        head;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  logic [6:0]  device_address;

  logic [7:0]  address_byte;
  logic [7:0]  expander_byte;
  logic        bus_write;
  logic [13:0] wait_us;
  logic        status;

  clcd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (s_tvalid),
    .cmd_ready      (s_tready),
    .func           (s_tuser),
    .char_code      (s_tdata[7:0]),
    .col            (s_tdata[15:8]),
    .row            (s_tdata[23:16]),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job),
    .device_address (device_address)
  );

  clcd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  clcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .device_address (device_address),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .address_byte   (address_byte),
    .expander_byte  (expander_byte),
    .bus_write      (bus_write),
    .wait_us        (wait_us),
    .status         (status),
    .last           (m_tlast)
  );

  // pack result fields
  assign m_tdata = {2'b00, wait_us, expander_byte, address_byte};
  assign m_tuser = {status, bus_write};

endmodule

`default_nettype wire
